@@ rtl/undirected_link_table_top_assert.svh @@
// ----------------------------------------------------------------------------
// Undirected link table assertion macros
// Shared wrappers for the concurrent checks of the link table top level.
// ----------------------------------------------------------------------------
`ifndef UNDIRECTED_LINK_TABLE_TOP_ASSERT_SVH
`define UNDIRECTED_LINK_TABLE_TOP_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define ULT_CHECK_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define ULT_CHECK_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ rtl/ult_pkg.sv @@
// ----------------------------------------------------------------------------
// Undirected link table package
// Field widths, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ult_pkg;

  localparam int NODE_W   = 16;
  localparam int RSSI_W   = 8;
  localparam int LIFE_W   = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(60 * 15);

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_FOUND = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TICK  = 3'd4;

  // Strobes broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic compare;
    logic write_hit;
    logic write_new;
    logic clear_hit;
    logic age;
    logic shift;
  } ult_ctl_t;

endpackage

`default_nettype wire

@@ rtl/ult_cell.sv @@
// ----------------------------------------------------------------------------
// Link table cell
// One slot of the table: endpoints, signal strength, lifetime and match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ult_cell #(
  parameter int KEY_W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ult_pkg::ult_ctl_t          ctl,
  input  logic [KEY_W-1:0]           req_a,
  input  logic [KEY_W-1:0]           req_b,
  input  logic [ult_pkg::RSSI_W-1:0] req_rssi,
  input  logic [ult_pkg::LIFE_W-1:0] lifetime,
  input  logic                       free_in,
  output logic                       free_out,
  output logic                       hit,
  output logic [ult_pkg::RSSI_W-1:0] hit_rssi,
  input  logic                       exp_in,
  output logic                       exp_out
);
  import ult_pkg::*;

  logic              valid;
  logic              exp;
  logic [KEY_W-1:0]  end_a;
  logic [KEY_W-1:0]  end_b;
  logic [RSSI_W-1:0] rssi;
  logic [LIFE_W-1:0] life;
  logic              match;
  logic              take;
  logic              dying;

  assign match = (end_a == req_a && end_b == req_b) ||
                 (end_a == req_b && end_b == req_a);

  // The lowest free slot claims a new link; the claim ripples upward.
  assign take     = !valid && !free_in;
  assign free_out = free_in || !valid;
  assign dying    = valid && (life <= LIFE_W'(1));

  assign hit_rssi = hit ? rssi : '0;
  assign exp_out  = exp;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
      exp   <= 1'b0;
    end else begin
      if (ctl.compare) begin
        hit <= valid && match;
      end
      if (ctl.write_new && take) begin
        valid <= 1'b1;
      end else if (ctl.clear_hit && hit) begin
        valid <= 1'b0;
      end else if (ctl.age && dying) begin
        valid <= 1'b0;
      end
      if (ctl.age) begin
        exp <= dying;
      end else if (ctl.shift) begin
        exp <= exp_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write_new && take) begin
      end_a <= req_a;
      end_b <= req_b;
    end
    if ((ctl.write_new && take) || (ctl.write_hit && hit)) begin
      rssi <= req_rssi;
      life <= lifetime;
    end else if (ctl.age && valid && !dying) begin
      life <= life - LIFE_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/undirected_link_table_top.sv @@
// ----------------------------------------------------------------------------
// Undirected link table
// Aging table of direction-free links between node addresses, one cell a slot.
// ----------------------------------------------------------------------------
//   Port group            Handshake              Moves
//   in_*  (cmd, nodes)    in_valid / in_ready    one request item
//   out_* (status, ...)   out_valid / out_ready  one result item
//   cfg_*                 cfg_we                 route_lifetime write
//
// Lookup, add and remove pass through request capture, a parallel compare in
// every cell, then the update with the free-slot claim rippling along the row.
// A tick ages the cells, then the expiry flags shift out of the row one cell a
// cycle into the expired counter. Reset is synchronous and empties the table.
// A stalled result holds the sequencer in its final step; a new request is
// taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module undirected_link_table_top #(
  parameter int MAX_LINKS = 32,
  parameter int ADDR_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ult_pkg::CMD_W-1:0]           cmd,
  input  logic [ult_pkg::NODE_W-1:0]          node_a,
  input  logic [ult_pkg::NODE_W-1:0]          node_b,
  input  logic signed [ult_pkg::RSSI_W-1:0]   rssi_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ult_pkg::STATUS_W-1:0]        status,
  output logic signed [ult_pkg::RSSI_W-1:0]   link_rssi,
  output logic [ult_pkg::COUNT_W-1:0]         link_count,
  output logic [ult_pkg::COUNT_W-1:0]         expired_count,
  input  logic                                cfg_we,
  input  logic [ult_pkg::LIFE_W-1:0]          cfg_wdata
);
  import ult_pkg::*;

  localparam int KEY_W   = (ADDR_BITS < NODE_W) ? ADDR_BITS : NODE_W;
  localparam int CNT_W   = $clog2(MAX_LINKS + 1);
  localparam int SHIFT_W = $clog2(MAX_LINKS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MATCH = 6'b000010,
    S_APPLY = 6'b000100,
    S_AGE   = 6'b001000,
    S_SHIFT = 6'b010000,
    S_TDONE = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [CMD_W-1:0]  req_cmd;
  logic [KEY_W-1:0]  req_a;
  logic [KEY_W-1:0]  req_b;
  logic [RSSI_W-1:0] req_rssi;
  logic [LIFE_W-1:0] route_lifetime;
  logic [CNT_W-1:0]  live_links, live_links_next;
  logic [CNT_W-1:0]  exp_total;
  logic [SHIFT_W-1:0] shift_cnt;

  logic                out_free;
  logic                result_load;
  logic [STATUS_W-1:0] status_next;
  logic [RSSI_W-1:0]   rssi_next;
  logic [CNT_W-1:0]    expired_next;

  ult_ctl_t          ctl;
  logic [MAX_LINKS:0] free_chain;
  logic [MAX_LINKS:0] exp_chain;
  logic [MAX_LINKS-1:0] hit_vec;
  logic [RSSI_W-1:0]  cell_rssi [MAX_LINKS];
  logic               any_hit;
  logic               any_free;
  logic [RSSI_W-1:0]  hit_rssi;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign ctl.compare   = (state == S_MATCH);
  assign ctl.age       = (state == S_AGE);
  assign ctl.shift     = (state == S_SHIFT);
  assign ctl.write_hit = (state == S_APPLY) && out_free && req_cmd == CMD_ADD && any_hit;
  assign ctl.write_new = (state == S_APPLY) && out_free && req_cmd == CMD_ADD && !any_hit;
  assign ctl.clear_hit = (state == S_APPLY) && out_free && req_cmd == CMD_REMOVE;

  assign free_chain[0]         = 1'b0;
  assign exp_chain[MAX_LINKS]  = 1'b0;
  assign any_free              = free_chain[MAX_LINKS];

  for (genvar i = 0; i < MAX_LINKS; i++) begin : g_cell
    ult_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .req_a    (req_a),
      .req_b    (req_b),
      .req_rssi (req_rssi),
      .lifetime (route_lifetime),
      .free_in  (free_chain[i]),
      .free_out (free_chain[i+1]),
      .hit      (hit_vec[i]),
      .hit_rssi (cell_rssi[i]),
      .exp_in   (exp_chain[i+1]),
      .exp_out  (exp_chain[i])
    );
  end

  // At most one cell matches, so an OR over the masked strengths selects it.
  always_comb begin
    hit_rssi = '0;
    for (int i = 0; i < MAX_LINKS; i++) begin
      hit_rssi = hit_rssi | cell_rssi[i];
    end
  end
  assign any_hit = |hit_vec;

  always_comb begin
    state_next      = state;
    live_links_next = live_links;
    result_load     = 1'b0;
    status_next     = ST_MISS;
    rssi_next       = '0;
    expired_next    = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == CMD_TICK) ? S_AGE : S_MATCH;
        end
      end
      S_MATCH: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          result_load = 1'b1;
          state_next  = S_IDLE;
          case (req_cmd)
            CMD_LOOKUP: begin
              if (any_hit) begin
                status_next = ST_FOUND;
                rssi_next   = hit_rssi;
              end
            end
            CMD_ADD: begin
              if (any_hit) begin
                status_next = ST_FOUND;
                rssi_next   = req_rssi;
              end else if (any_free) begin
                status_next     = ST_ADDED;
                rssi_next       = req_rssi;
                live_links_next = live_links + CNT_W'(1);
              end else begin
                status_next = ST_FULL;
              end
            end
            CMD_REMOVE: begin
              if (any_hit) begin
                status_next     = ST_FOUND;
                rssi_next       = hit_rssi;
                live_links_next = live_links - CNT_W'(1);
              end
            end
            default: begin
              status_next = ST_MISS;
            end
          endcase
        end
      end
      S_AGE: begin
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (shift_cnt == SHIFT_W'(MAX_LINKS - 1)) begin
          state_next = S_TDONE;
        end
      end
      S_TDONE: begin
        if (out_free) begin
          result_load     = 1'b1;
          state_next      = S_IDLE;
          status_next     = ST_TICK;
          expired_next    = exp_total;
          live_links_next = live_links - exp_total;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      live_links     <= '0;
      out_valid      <= 1'b0;
      route_lifetime <= LIFETIME_RESET;
      shift_cnt      <= '0;
      exp_total      <= '0;
    end else begin
      state      <= state_next;
      live_links <= live_links_next;
      if (cfg_we) begin
        route_lifetime <= cfg_wdata;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_AGE) begin
        shift_cnt <= '0;
        exp_total <= '0;
      end else if (state == S_SHIFT) begin
        shift_cnt <= shift_cnt + SHIFT_W'(1);
        exp_total <= exp_total + CNT_W'(exp_chain[0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd  <= cmd;
      req_a    <= node_a[KEY_W-1:0];
      req_b    <= node_b[KEY_W-1:0];
      req_rssi <= rssi_in;
    end
    if (result_load) begin
      status        <= status_next;
      link_rssi     <= rssi_next;
      link_count    <= COUNT_W'(live_links_next);
      expired_count <= COUNT_W'(expired_next);
    end
  end

`include "undirected_link_table_top_assert.svh"

  `ULT_CHECK_NOW(a_count_bound, 1'b1, live_links <= CNT_W'(MAX_LINKS), "too many links")
  `ULT_CHECK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "taken while busy")
  `ULT_CHECK_NOW(a_expired_only_tick, out_valid && status != ST_TICK, expired_count == '0, "stray")

endmodule

`default_nettype wire
